// File: hw/rtl/sabm_pkg.sv
// ----------------------------------------------------------------------------
// sabm_pkg
// Shared types and constants for the scaled alpha to bitmask row block.
// ----------------------------------------------------------------------------
package sabm_pkg;

    localparam int MAX_IN_W  = 1024;
    localparam int MAX_OUT_W = 512;

    localparam int IDX_W  = $clog2(MAX_IN_W);      // store address
    localparam int FILL_W = IDX_W + 1;             // load position / fill count
    localparam int IW_W   = 11;                    // in_width
    localparam int OW_W   = 10;                    // out_width
    localparam int SC_W   = 10;                    // start_column
    localparam int SRC_W  = IW_W + 1;              // start_column + step

    localparam logic [7:0] ALPHA_LIMIT = 8'd127;
    localparam logic [2:0] BIT_LAST    = 3'd7;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_OUT_WIDTH = 2'd1;
    localparam logic [1:0] REG_START_COL = 2'd2;

    localparam logic [IW_W-1:0] IN_WIDTH_RST  = IW_W'(1024);
    localparam logic [OW_W-1:0] OUT_WIDTH_RST = OW_W'(512);

    typedef struct packed {
        logic [7:0] alpha;
        logic       last_pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] mask_byte;
        logic       last_byte;
    } t_out;

    // classified pixel as queued between front and back
    typedef struct packed {
        logic mask_bit;
        logic last;
    } t_pix;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    function automatic logic [OW_W-1:0] eff_out_width(input logic [OW_W-1:0] w);
        logic [OW_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = OW_W'(1);
        end else if (w > OW_W'(MAX_OUT_W)) begin
            r = OW_W'(MAX_OUT_W);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sabm_front.sv
// ----------------------------------------------------------------------------
// sabm_front
// Accepts pixels, turns alpha into a transparency bit and queues them.
// ----------------------------------------------------------------------------
module sabm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sabm_pkg::t_in  i_item,
    input  logic           i_pop,
    output logic           o_q_valid,
    output sabm_pkg::t_pix o_head
);
    import sabm_pkg::*;

    t_pix            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            pop;
    t_pix            pix;

    assign busy      = (r_cnt == Q_CW'(Q_DEPTH));
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_pop && o_q_valid;
    assign o_head    = r_q[r_rp];

    always_comb begin
        pix.mask_bit = (i_item.alpha < ALPHA_LIMIT);
        pix.last     = i_item.last_pixel;
    end

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= pix;
        end
    end

endmodule

// File: hw/rtl/sabm_back.sv
// ----------------------------------------------------------------------------
// sabm_back
// Line store load, step divide, nearest-neighbour walk and byte packing.
// ----------------------------------------------------------------------------
module sabm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  sabm_pkg::t_pix            i_head,
    output logic                      o_pop,
    input  logic [sabm_pkg::IW_W-1:0] i_in_width,
    input  logic [sabm_pkg::OW_W-1:0] i_out_width,
    input  logic [sabm_pkg::SC_W-1:0] i_start_col,
    output logic                      o_strobe,
    output sabm_pkg::t_out            o_result
);
    import sabm_pkg::*;

    t_back_state r_state, n_state;

    logic             r_mem [MAX_IN_W];
    logic             r_rd_bit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [IDX_W-1:0] mem_ra;

    logic [FILL_W-1:0] r_load_pos, n_load_pos;
    logic [FILL_W-1:0] r_fill, n_fill;   // entries below this have been written
    logic [3:0]        r_div_cnt, n_div_cnt;
    logic [OW_W-1:0]   r_rem, n_rem;     // step remainder after divide
    logic [IW_W-1:0]   r_quo, n_quo;     // step quotient after divide
    logic [IW_W-1:0]   r_q, n_q;
    logic [OW_W-1:0]   r_r, n_r;
    logic [OW_W-1:0]   r_col, n_col;
    logic              r_b_vld, n_b_vld;
    logic              r_b_ok, n_b_ok;
    logic [2:0]        r_b_pos, n_b_pos;
    logic              r_b_last, n_b_last;
    logic [7:0]        r_pack, n_pack;
    logic              r_strobe, n_strobe;
    t_out              r_out, n_out;

    logic [OW_W:0]   trial;
    logic [OW_W:0]   rsum;
    logic [SRC_W-1:0] src;
    logic [7:0]      byte_v;
    logic            col_last;
    logic            div_done;

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    assign col_last = (r_col == i_out_width - 1'b1);
    assign div_done = (r_div_cnt == 4'(IW_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_q_valid && i_head.last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (col_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_load_pos[IDX_W-1:0];
        n_load_pos = r_load_pos;
        n_fill     = r_fill;
        n_div_cnt  = r_div_cnt;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_q        = r_q;
        n_r        = r_r;
        n_col      = r_col;
        n_b_vld    = 1'b0;
        n_b_ok     = r_b_ok;
        n_b_pos    = r_b_pos;
        n_b_last   = r_b_last;
        n_pack     = r_pack;
        n_strobe   = 1'b0;
        n_out      = r_out;
        trial      = {r_rem, r_quo[IW_W-1]};
        rsum       = {1'b0, r_r} + {1'b0, r_rem};
        src        = SRC_W'(i_start_col) + SRC_W'(r_q);
        mem_ra     = src[IDX_W-1:0];
        byte_v     = r_pack;

        case (r_state)
            ST_LOAD: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    if (r_load_pos < FILL_W'(MAX_IN_W)) begin
                        mem_we     = 1'b1;
                        n_load_pos = r_load_pos + 1'b1;
                        if (r_load_pos >= r_fill) begin
                            n_fill = r_load_pos + 1'b1;
                        end
                    end
                    if (i_head.last) begin
                        n_load_pos = '0;
                        n_rem      = '0;
                        n_quo      = i_in_width;
                        n_div_cnt  = '0;
                    end
                end
            end
            ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (trial >= {1'b0, i_out_width}) begin
                    n_rem = OW_W'(trial - {1'b0, i_out_width});
                    n_quo = {r_quo[IW_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[OW_W-1:0];
                    n_quo = {r_quo[IW_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                n_q       = '0;
                n_r       = '0;
                n_col     = '0;
            end
            ST_EMIT: begin
                n_b_vld  = 1'b1;
                n_b_ok   = (src < SRC_W'(r_fill));
                n_b_pos  = r_col[2:0];
                n_b_last = col_last;
                n_col    = r_col + 1'b1;
                if (rsum >= {1'b0, i_out_width}) begin
                    n_r = OW_W'(rsum - {1'b0, i_out_width});
                    n_q = r_q + r_quo + 1'b1;
                end else begin
                    n_r = rsum[OW_W-1:0];
                    n_q = r_q + r_quo;
                end
            end
            default: ;
        endcase

        // pack stage, in the cycle after the store read
        if (r_b_vld) begin
            byte_v[r_b_pos] = r_rd_bit & r_b_ok;
            if (r_b_pos == BIT_LAST || r_b_last) begin
                n_strobe        = 1'b1;
                n_out.mask_byte = byte_v;
                n_out.last_byte = r_b_last;
                n_pack          = '0;
            end else begin
                n_pack = byte_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_pos <= '0;
            r_fill     <= '0;
            r_b_vld    <= 1'b0;
            r_pack     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_fill     <= n_fill;
            r_b_vld    <= n_b_vld;
            r_pack     <= n_pack;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_cnt <= n_div_cnt;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_q       <= n_q;
        r_r       <= n_r;
        r_col     <= n_col;
        r_b_ok    <= n_b_ok;
        r_b_pos   <= n_b_pos;
        r_b_last  <= n_b_last;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_head.mask_bit;
        end
        r_rd_bit <= r_mem[mem_ra];
    end

endmodule

// File: hw/rtl/scaled_alpha_to_bitmask_row.sv
// ----------------------------------------------------------------------------
// scaled_alpha_to_bitmask_row
// Alpha row to nearest-neighbour scaled 1bpp transparency mask.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy is low; a four-entry queue sits
// between the intake and the line store, so busy only rises while a row end
// is being divided or emitted and the queue has filled. After the pixel
// marked last_pixel the back end runs the step divide, then walks one
// output column per cycle (out_width, limited to 1..512); each column's
// store read is registered, then packed into the registered output byte.
// Each byte is shown for a single cycle with o_result_strobe; the
// receiver cannot stall, so it must take every strobed transfer. Bit 0 is
// the leftmost column.
// ----------------------------------------------------------------------------
module scaled_alpha_to_bitmask_row (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sabm_pkg::t_in                i_item,
    output logic                         o_result_strobe,
    output sabm_pkg::t_out               o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sabm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sabm_pkg::*;

    logic [IW_W-1:0] r_in_width;
    logic [OW_W-1:0] r_out_width;
    logic [SC_W-1:0] r_start_col;
    logic [1:0]      reg_idx;
    logic            wr_en;
    logic            q_valid;
    logic            pop;
    t_pix            head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= IN_WIDTH_RST;
            r_out_width <= OUT_WIDTH_RST;
            r_start_col <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IN_WIDTH:  r_in_width  <= pwdata[IW_W-1:0];
                REG_OUT_WIDTH: r_out_width <= pwdata[OW_W-1:0];
                REG_START_COL: r_start_col <= pwdata[SC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IN_WIDTH:  prdata = 32'(r_in_width);
            REG_OUT_WIDTH: prdata = 32'(r_out_width);
            REG_START_COL: prdata = 32'(r_start_col);
            default:       prdata = '0;
        endcase
    end

    sabm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_pop     (pop),
        .o_q_valid (q_valid),
        .o_head    (head)
    );

    sabm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .i_in_width  (r_in_width),
        .i_out_width (eff_out_width(r_out_width)),
        .i_start_col (r_start_col),
        .o_strobe    (o_result_strobe),
        .o_result    (o_result)
    );

endmodule

// File: tb/sv/scaled_alpha_to_bitmask_row_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_alpha_to_bitmask_row_tb
// Self-checking bench for the alpha row to scaled 1bpp mask block.
// ----------------------------------------------------------------------------
// Pixels are pushed through the start/busy command port and mirrored into a
// line-store model that resamples each finished row and queues the expected
// mask bytes. Every strobed byte is compared against the oldest queued one.
// Registers are rewritten over the APB port between segments, once the
// block has drained, and read back. The run opens with directed rows that
// hit the width limits, then random rows under several settings and sender
// gap rates.
// ----------------------------------------------------------------------------
module scaled_alpha_to_bitmask_row_tb;
    import sabm_pkg::*;

    class mask_row_scoreboard;
        logic            line_bits[MAX_IN_W];
        int unsigned     fill_pos;
        logic [IW_W-1:0] in_width;
        logic [OW_W-1:0] out_width;
        logic [SC_W-1:0] start_col;
        t_out            expected_bytes[$];
        int unsigned     errors;
        int unsigned     pixels_seen;
        int unsigned     rows_done;
        int unsigned     bytes_checked;

        function new();
            foreach (line_bits[k]) line_bits[k] = 1'b0;
            fill_pos      = 0;
            in_width      = IN_WIDTH_RST;
            out_width     = OUT_WIDTH_RST;
            start_col     = '0;
            errors        = 0;
            pixels_seen   = 0;
            rows_done     = 0;
            bytes_checked = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 100) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
        endtask

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                REG_IN_WIDTH:  in_width  = val[IW_W-1:0];
                REG_OUT_WIDTH: out_width = val[OW_W-1:0];
                REG_START_COL: start_col = val[SC_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input logic [1:0] idx);
            logic [31:0] v;
            v = '0;
            case (idx)
                REG_IN_WIDTH:  v = 32'(in_width);
                REG_OUT_WIDTH: v = 32'(out_width);
                REG_START_COL: v = 32'(start_col);
                default: ;
            endcase
            return v;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // nearest-neighbour walk of the stored row, packed LSB first
        function void resample_row();
            int unsigned cols, nbytes, nout, src;
            logic [7:0]  acc;
            t_out        b;
            cols = out_width;
            if (cols == 0) cols = 1;
            if (cols > MAX_OUT_W) cols = MAX_OUT_W;
            nbytes = (cols + 7) / 8;
            nout   = 0;
            acc    = '0;
            for (int unsigned j = 0; j < cols; j++) begin
                src = start_col + (in_width * j) / cols;
                acc[j % 8] = (src < MAX_IN_W) ? line_bits[src] : 1'b0;
                if (3'(j) == BIT_LAST || j + 1 == cols) begin
                    nout++;
                    b.mask_byte = acc;
                    b.last_byte = (nout == nbytes);
                    expected_bytes.push_back(b);
                    acc = '0;
                end
            end
        endfunction

        function void note_pixel(input t_in px);
            pixels_seen++;
            if (fill_pos < MAX_IN_W) begin
                line_bits[fill_pos] = (px.alpha < ALPHA_LIMIT);
                fill_pos++;
            end
            if (px.last_pixel) begin
                resample_row();
                fill_pos = 0;
                rows_done++;
            end
        endfunction

        task check_byte(input t_out got);
            t_out want;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected mask byte %02h last=%0b",
                                 got.mask_byte, got.last_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (got.mask_byte !== want.mask_byte) begin
                    report($sformatf("mask_byte got %02h want %02h",
                                     got.mask_byte, want.mask_byte));
                end
                if (got.last_byte !== want.last_byte) begin
                    report($sformatf("last_byte got %0b want %0b",
                                     got.last_byte, want.last_byte));
                end
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in                i_item;
    logic               o_result_strobe;
    t_out               o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    mask_row_scoreboard sb = new();
    int unsigned        idle_pct;
    int unsigned        settings_used;

    scaled_alpha_to_bitmask_row i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_pixel(i_item);
            end
            if (o_result_strobe) begin
                sb.check_byte(o_result);
            end
        end
    end

    task send_pixel(input logic [7:0] alpha, input logic last);
        int unsigned gap;
        t_in         px;
        px.alpha      = alpha;
        px.last_pixel = last;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // drop start and let the block drain before touching registers
    task drain_block();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        // read back in a second transfer
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = sb.reg_value(idx);
        if (prdata !== want) begin
            sb.report($sformatf("reg %0d read %08h want %08h", idx, prdata, want));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task apply_setting(input logic [31:0] iw, input logic [31:0] ow,
                       input logic [31:0] sc);
        drain_block();
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_START_COL, sc);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_alpha();
        logic [7:0] near_limit[5] = '{8'd0, 8'd126, 8'd127, 8'd128, 8'd255};
        if ($urandom_range(0, 3) == 0) begin
            return near_limit[$urandom_range(0, 4)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_setting();
        logic [31:0] wide_iw[4] = '{32'd0, 32'd1, 32'd1024, 32'd2047};
        logic [31:0] wide_ow[4] = '{32'd0, 32'd1, 32'd512, 32'd1023};
        if ($urandom_range(0, 7) == 0) begin
            apply_setting(wide_iw[$urandom_range(0, 3)], wide_ow[$urandom_range(0, 3)],
                          $urandom_range(0, 1) ? 32'd1023 : 32'd0);
        end else begin
            // mostly short output rows so the run stays quick
            apply_setting($urandom_range(1, 48), $urandom_range(1, 40),
                          $urandom_range(0, 16));
        end
    endtask

    initial begin
        #2_000_000;
        $display("** scaled_alpha_to_bitmask_row: FAILED **");
        $finish;
    end

    initial begin
        automatic logic [7:0] edge_alpha[8] = '{8'd0, 8'd126, 8'd127, 8'd128, 8'd255,
                                                8'd1, 8'd254, 8'd64};
        int unsigned left, row_len;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_pct      = 0;
        settings_used = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset widths: 512 columns over the whole store
        for (int k = 0; k < 5; k++) send_pixel(edge_alpha[k], k == 4);

        apply_setting(8, 8, 0);
        for (int k = 0; k < 8; k++) send_pixel(edge_alpha[k], k == 7);

        // zero source and output widths
        apply_setting(0, 0, 3);
        for (int k = 0; k < 4; k++) send_pixel(pick_alpha(), k == 3);

        // oversized output width, samples run off the end of the store
        apply_setting(2047, 1023, 1023);
        send_pixel(8'd10, 1'b1);

        for (int seg = 0; seg < 9; seg++) begin
            idle_pct = (seg < 3) ? 16 : (seg < 6) ? 67 : 0;
            random_setting();
            left = 18;
            while (left > 0) begin
                row_len = $urandom_range(1, 12);
                if (row_len > left) row_len = left;
                for (int k = 0; k < row_len; k++) begin
                    send_pixel(pick_alpha(), k == row_len - 1);
                end
                left -= row_len;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("Loaded %0d pixels in %0d rows under %0d register settings,",
                 sb.pixels_seen, sb.rows_done, settings_used + 1);
        $display("checked %0d mask bytes, %0d mismatches.", sb.bytes_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** scaled_alpha_to_bitmask_row: PASSED **");
        end else begin
            $display("** scaled_alpha_to_bitmask_row: FAILED **");
        end
        $finish;
    end

endmodule
